### rtl/core/ssrt_pkg.sv
// Shared types and constants for the stepper speed ramp and step timer.
package ssrt_pkg;

  // Fixed-point speed format and motor geometry
  localparam int FRAC_BITS     = 16;
  localparam int STEPS_PER_REV = 200;

  // Field and register widths
  localparam int SPEED_W     = 24;
  localparam int TGT_W       = 8;
  localparam int ELAPSED_W   = 20;
  localparam int RPM_W       = 10;
  localparam int ACCEL_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int INTERVAL_W  = 32;
  localparam int RPM_STEPS_W = 18;
  localparam int MAG_W       = SPEED_W - 1;
  localparam int DEN_W       = RPM_STEPS_W + MAG_W;
  localparam int PROD_W      = ACCEL_W + ELAPSED_W;

  // Divider geometry: quotient bits produced one a cycle
  localparam int QUOT_W   = 32;
  localparam int NUM_HI_W = 20;
  localparam int NUM_W    = NUM_HI_W + QUOT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // Ramp step floor(rate*time*2^16/1e6) = floor(p*2^10/15625), split as
  // q = p/15625 and r = p%15625, giving q*2^10 + floor(r*2^10/15625).
  // Products of 2^28 and above give a step beyond any speed difference.
  localparam int RAMP_P_W    = 28;
  localparam int RAMP_Q_W    = 15;
  localparam int RAMP_R_W    = 14;
  localparam int RAMP_F_W    = 10;
  localparam int RAMP_STEP_W = RAMP_Q_W + RAMP_F_W;
  localparam int RECIP_Q_W   = 29;
  localparam int RECIP_Q_SH  = 42;
  localparam int RECIP_F_W   = 25;
  localparam int RECIP_F_SH  = 28;
  localparam logic [RAMP_R_W-1:0]  RAMP_DIVISOR = 14'd15625;
  // ceil(2^42 / 15625), exact for dividends below 2^28
  localparam logic [RECIP_Q_W-1:0] RECIP_Q = 29'd281474977;
  // ceil(2^38 / 15625), applied to r*2^10 and so shifted by 28
  localparam logic [RECIP_F_W-1:0] RECIP_F = 25'd17592187;

  // Target clamp limit in percent
  localparam logic signed [TGT_W-1:0] TGT_MAX = 8'sd100;
  localparam logic signed [TGT_W-1:0] TGT_MIN = -8'sd100;

  // Reset value of max_rpm folded into steps per minute
  localparam logic [RPM_STEPS_W-1:0] RPM_STEPS_RESET = RPM_STEPS_W'(60 * STEPS_PER_REV);

  // 6e9 * 2^FRAC_BITS: microseconds per minute times 100 percent, in Q16
  localparam logic [NUM_W-1:0] INTERVAL_NUM = NUM_W'(64'd6000000000 << FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_RPM = 1'b0,
    REG_ACCEL   = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARGET,
    ST_RAMP_CHK,
    ST_RAMP_QUOT,
    ST_RAMP_REM,
    ST_RAMP_FRAC,
    ST_MOVE,
    ST_APPLY,
    ST_INT_START,
    ST_INT_DIV,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     load_target;
    logic     calc_prod;
    logic     ramp_quot;
    logic     ramp_rem;
    logic     ramp_frac;
    logic     div_start;
    logic     move_speed;
    logic     calc_den;
    logic     interval_zero;
    logic     interval_load;
    logic     finish;
  } ssrt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic jump;
    logic ramp_go;
    logic speed_zero;
    logic div_done;
    logic out_free;
  } ssrt_status_t;

endpackage

### rtl/core/ssrt_div.sv
// Iterative restoring divider, one quotient bit a cycle, saturating at 32 bits.
module ssrt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ssrt_pkg::NUM_HI_W-1:0]  num_hi,
  input  logic [ssrt_pkg::QUOT_W-1:0]    num_lo,
  input  logic [ssrt_pkg::DEN_W-1:0]     den,
  output logic                           done,
  output logic [ssrt_pkg::QUOT_W-1:0]    quot
);
  import ssrt_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [QUOT_W-1:0]    sh;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       trial_sub;
  logic                 qbit;
  logic                 sat;

  // Quotient overflows when the upper numerator part already reaches the divisor
  assign sat = {{(DEN_W-NUM_HI_W){1'b0}}, num_hi} >= den;

  // Shift the next numerator bit into the partial remainder and trial subtract
  assign trial     = {rem, sh[QUOT_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign qbit      = trial >= {1'b0, den};

  // Sequence the iterations; numerator bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (sat) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and shared numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {{(DEN_W-NUM_HI_W){1'b0}}, num_hi};
      sh  <= sat ? '1 : num_lo;
    end else if (busy) begin
      rem <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= {sh[QUOT_W-2:0], qbit};
    end
  end

  assign quot = sh;

endmodule

### rtl/core/ssrt_dp.sv
// Datapath: speed state, ramp arithmetic, interval divider, step timer and output register.
module ssrt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ssrt_pkg::ssrt_cmd_t                  cmd,
  output ssrt_pkg::ssrt_status_t               st,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [ssrt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 operation,
  input  logic signed [ssrt_pkg::TGT_W-1:0]    target_speed,
  input  logic [ssrt_pkg::ELAPSED_W-1:0]       elapsed_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 step_pulse,
  output logic                                 direction,
  output logic                                 release_coils,
  output logic signed [ssrt_pkg::SPEED_W-1:0]  current_speed,
  output logic [ssrt_pkg::INTERVAL_W-1:0]      step_interval_us
);
  import ssrt_pkg::*;

  // Configuration
  logic [RPM_STEPS_W-1:0] rpm_steps;
  logic [ACCEL_W-1:0]     accel;

  // Captured transaction
  logic                    op_r;
  logic signed [TGT_W-1:0] tgt_r;
  logic [ELAPSED_W-1:0]    elapsed_r;

  // Architectural state
  logic signed [TGT_W-1:0]   target_reg;
  logic signed [SPEED_W-1:0] cur;
  logic [INTERVAL_W-1:0]     interval;
  logic [INTERVAL_W-1:0]     tss;
  logic                      released;

  // Working registers
  logic [PROD_W-1:0]      prod;
  logic [DEN_W-1:0]       den;
  logic [RAMP_Q_W-1:0]    ramp_q;
  logic [RAMP_R_W-1:0]    ramp_r;
  logic [RAMP_STEP_W-1:0] ramp_step;

  // Divider interface
  logic                div_done;
  logic [QUOT_W-1:0]   quot;

  // Combinational helpers
  logic signed [TGT_W-1:0]        tgt_clamped;
  logic signed [SPEED_W-1:0]      target_q;
  logic signed [SPEED_W-1:0]      jump_speed;
  logic [SPEED_W-1:0]             abs_cur;
  logic [MAG_W-1:0]               mag;
  logic signed [SPEED_W:0]        diff;
  logic [SPEED_W:0]               adiff;
  logic                           reach;
  logic signed [SPEED_W:0]        moved;
  logic [INTERVAL_W:0]            tss_sum;
  logic [INTERVAL_W-1:0]          tss_sat;
  logic                           fire;
  logic                           ramp_big;
  logic [RAMP_P_W+RECIP_Q_W-1:0]  ramp_qprod;
  logic [RAMP_P_W-1:0]            ramp_back;
  logic [RAMP_P_W-1:0]            ramp_rem;
  logic [RECIP_F_SH+RAMP_F_W-1:0] ramp_fprod;

  assign cfg_ready = 1'b1;

  // Register writes; max_rpm is kept premultiplied by steps per revolution
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_steps <= RPM_STEPS_RESET;
      accel     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RPM: rpm_steps <= RPM_STEPS_W'(cfg_data[RPM_W-1:0] * STEPS_PER_REV);
        REG_ACCEL:   accel     <= cfg_data[ACCEL_W-1:0];
        default:     ;
      endcase
    end
  end

  // Clamp the requested target to the legal percent range
  always_comb begin
    if (tgt_r > TGT_MAX) begin
      tgt_clamped = TGT_MAX;
    end else if (tgt_r < TGT_MIN) begin
      tgt_clamped = TGT_MIN;
    end else begin
      tgt_clamped = tgt_r;
    end
  end

  assign jump_speed = {tgt_clamped, {FRAC_BITS{1'b0}}};
  assign target_q   = {target_reg, {FRAC_BITS{1'b0}}};
  assign abs_cur    = cur[SPEED_W-1] ? -cur : cur;
  assign mag        = abs_cur[MAG_W-1:0];

  // Ramp step terms: quotient, remainder and fraction of p / 15625
  assign ramp_big   = |prod[PROD_W-1:RAMP_P_W];
  assign ramp_qprod = prod[RAMP_P_W-1:0] * RECIP_Q;
  assign ramp_back  = ramp_q * RAMP_DIVISOR;
  assign ramp_rem   = prod[RAMP_P_W-1:0] - ramp_back;
  assign ramp_fprod = ramp_r * RECIP_F;

  // Ramp move: step toward the target without overshoot
  assign diff  = {target_q[SPEED_W-1], target_q} - {cur[SPEED_W-1], cur};
  assign adiff = diff[SPEED_W] ? -diff : diff;
  assign reach = ramp_big || (adiff <= ramp_step);
  assign moved = diff[SPEED_W] ? {cur[SPEED_W-1], cur} - {1'b0, ramp_step[SPEED_W-1:0]}
                               : {cur[SPEED_W-1], cur} + {1'b0, ramp_step[SPEED_W-1:0]};

  // Saturating time since the last step
  assign tss_sum = {1'b0, tss} + {{(INTERVAL_W-ELAPSED_W+1){1'b0}}, elapsed_r};
  assign tss_sat = tss_sum[INTERVAL_W] ? '1 : tss_sum[INTERVAL_W-1:0];
  assign fire    = (interval != '0) && (tss_sat >= interval);

  // Interval division: 6e9*2^16 over the speed term
  ssrt_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num_hi (INTERVAL_NUM[NUM_W-1:QUOT_W]),
    .num_lo (INTERVAL_NUM[QUOT_W-1:0]),
    .den    (den),
    .done   (div_done),
    .quot   (quot)
  );

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= operation;
      tgt_r     <= target_speed;
      elapsed_r <= elapsed_us;
    end
  end

  // Multiplications, each registered before use
  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      prod <= accel * elapsed_r;
    end
    if (cmd.calc_den) begin
      den <= rpm_steps * mag;
    end
  end

  // Ramp step computed in turn: quotient, remainder, then fraction bits
  always_ff @(posedge clk) begin
    if (cmd.ramp_quot) begin
      ramp_q <= ramp_qprod[RECIP_Q_SH +: RAMP_Q_W];
    end
    if (cmd.ramp_rem) begin
      ramp_r <= ramp_rem[RAMP_R_W-1:0];
    end
    if (cmd.ramp_frac) begin
      ramp_step <= {ramp_q, ramp_fprod[RECIP_F_SH +: RAMP_F_W]};
    end
  end

  // Speed, target, interval and step timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_reg <= '0;
      cur        <= '0;
      interval   <= '0;
      tss        <= '0;
      released   <= 1'b0;
    end else begin
      if (cmd.load_target && op_r) begin
        target_reg <= tgt_clamped;
        if (accel == '0) begin
          cur <= jump_speed;
        end
      end
      if (cmd.move_speed) begin
        cur <= reach ? target_q : moved[SPEED_W-1:0];
      end
      if (cmd.interval_zero) begin
        interval <= '0;
      end
      if (cmd.interval_load) begin
        interval <= quot;
      end
      if (cmd.finish) begin
        if (interval == '0) begin
          released <= 1'b1;
          tss      <= tss_sat;
        end else begin
          released <= 1'b0;
          tss      <= fire ? '0 : tss_sat;
        end
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      step_pulse       <= fire;
      direction        <= !cur[SPEED_W-1] && (cur != '0);
      release_coils    <= (interval == '0) && !released;
      current_speed    <= cur;
      step_interval_us <= interval;
    end
  end

  // Status to the controller
  assign st.jump       = op_r && (accel == '0);
  assign st.ramp_go    = (accel != '0) && (cur != target_q);
  assign st.speed_zero = (cur == '0);
  assign st.div_done   = div_done;
  assign st.out_free   = !out_valid || !out_stall;

endmodule

### rtl/core/ssrt_ctrl.sv
// Controller state machine sequencing target load, ramp, interval division and result.
module ssrt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ssrt_pkg::ssrt_status_t st,
  output ssrt_pkg::ssrt_cmd_t    cmd
);
  import ssrt_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd.load_target = 1'b1;
        state_next      = st.jump ? ST_APPLY : ST_RAMP_CHK;
      end
      ST_RAMP_CHK: begin
        if (st.ramp_go) begin
          cmd.calc_prod = 1'b1;
          state_next    = ST_RAMP_QUOT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_RAMP_QUOT: begin
        cmd.ramp_quot = 1'b1;
        state_next    = ST_RAMP_REM;
      end
      ST_RAMP_REM: begin
        cmd.ramp_rem = 1'b1;
        state_next   = ST_RAMP_FRAC;
      end
      ST_RAMP_FRAC: begin
        cmd.ramp_frac = 1'b1;
        state_next    = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move_speed = 1'b1;
        state_next     = ST_APPLY;
      end
      ST_APPLY: begin
        if (st.speed_zero) begin
          cmd.interval_zero = 1'b1;
          state_next        = ST_FINISH;
        end else begin
          cmd.calc_den = 1'b1;
          state_next   = ST_INT_START;
        end
      end
      ST_INT_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_INT_DIV;
      end
      ST_INT_DIV: begin
        if (st.div_done) begin
          cmd.interval_load = 1'b1;
          state_next        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/stepper_speed_ramp_step_timer_core.sv
// Stepper speed ramp and step timer: top level joining controller and datapath.
// Each transaction carries elapsed microseconds and optionally a new target speed in
// percent (clamped to -100..100); the block ramps a signed Q16 speed toward it at
// accel_pct_per_s, derives the step interval 6e9*2^16/(max_rpm*200*|speed|) saturated
// to 32 bits, and issues a step when the saturating time since the last step reaches
// that interval, or a one-shot coil release on entering standstill. One transaction is
// processed at a time. A tick without speed change skips the interval divider; a target
// jump or a ramp move runs that radix-2 divider, which produces one quotient bit per
// cycle. The ramp step (rate*time*2^16/1e6) is taken by reciprocal multiplication in
// turn: quotient, remainder, then fraction bits. A new speed of zero skips the divider,
// and a saturated interval leaves it in the cycle after its start.
// The result sits in an output register, so the next transaction is taken while it
// waits; a further result waits for that register to be taken. Configuration writes are
// always ready and must be made only while the block is idle.
module stepper_speed_ramp_step_timer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [ssrt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic signed [ssrt_pkg::TGT_W-1:0]    target_speed,
  input  logic [ssrt_pkg::ELAPSED_W-1:0]       elapsed_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 step_pulse,
  output logic                                 direction,
  output logic                                 release_coils,
  output logic signed [ssrt_pkg::SPEED_W-1:0]  current_speed,
  output logic [ssrt_pkg::INTERVAL_W-1:0]      step_interval_us
);
  import ssrt_pkg::*;

  ssrt_cmd_t    cmd;
  ssrt_status_t st;

  // Sequencer
  ssrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and state
  ssrt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .operation        (operation),
    .target_speed     (target_speed),
    .elapsed_us       (elapsed_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .step_pulse       (step_pulse),
    .direction        (direction),
    .release_coils    (release_coils),
    .current_speed    (current_speed),
    .step_interval_us (step_interval_us)
  );

endmodule
